// ----- rtl/divider_set_lookup_utf8_read_unit_assert.svh -----
// Assertion macros shared by the checker files.
`ifndef DIVIDER_SET_LOOKUP_UTF8_READ_UNIT_ASSERT_SVH
`define DIVIDER_SET_LOOKUP_UTF8_READ_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DSLU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dslu assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DSLU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dslu assertion failed");

`endif

// ----- rtl/dslu_pkg.sv -----
// Shared types, codes and constants of the divider-set lookup unit.
package dslu_pkg;

  localparam int unsigned CP_W          = 31;
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned TOTAL_W       = 11;
  localparam int unsigned BUILTIN_TOTAL = 65;
  localparam int unsigned BUILTIN_IW    = $clog2(BUILTIN_TOTAL);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SRC_TABLE   = 2'd0,
    SRC_BUILTIN = 2'd1,
    SRC_EMPTY   = 2'd2,
    SRC_UNUSED  = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_ORDER = 2'd3
  } status_e;

  localparam logic [7:0] LEAD_2    = 8'hC0;
  localparam logic [7:0] LEAD_3    = 8'hE0;
  localparam logic [7:0] LEAD_4    = 8'hF0;
  localparam logic [7:0] LEAD_5    = 8'hF8;
  localparam logic [7:0] LEAD_6    = 8'hFC;
  localparam logic [7:0] CONT_MARK = 8'h80;
  localparam logic [7:0] CONT_MASK = 8'h3F;

  typedef struct packed {
    logic [2:0]      count;
    logic [5:0][7:0] bytes;
  } utf8_t;

  typedef logic [BUILTIN_TOTAL-1:0][6:0] builtin_lut_t;

  function automatic logic is_alnum_ascii(logic [6:0] c);
    return (c >= 7'h30 && c <= 7'h39) || (c >= 7'h41 && c <= 7'h5A) ||
           (c >= 7'h61 && c <= 7'h7A);
  endfunction

  // Continuation byte from the low six bits of x.
  function automatic logic [7:0] cont_byte(logic [5:0] x);
    return CONT_MARK | ({2'b00, x} & CONT_MASK);
  endfunction

  // Members of the built-in set in ascending order, built at elaboration.
  function automatic builtin_lut_t build_builtin_lut();
    builtin_lut_t lut;
    int           n;
    lut = '0;
    n   = 0;
    for (int c = 1; c < 128; c++) begin
      if (!is_alnum_ascii(7'(c))) begin
        lut[n] = 7'(c);
        n++;
      end
    end
    return lut;
  endfunction

  localparam builtin_lut_t BUILTIN_LUT = build_builtin_lut();

endpackage

// ----- rtl/dslu_table_mem.sv -----
// Entry table: one write port, one read port, registered read data.
module dslu_table_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/dslu_utf8_enc.sv -----
// Original-style UTF-8 encoder, 1 to 6 bytes for a 31-bit code point.
module dslu_utf8_enc import dslu_pkg::*; (
  input  logic [CP_W-1:0] value_i,
  output utf8_t           enc_o
);

  always_comb begin
    enc_o = '0;
    if (value_i[30:7] == '0) begin
      enc_o.count    = 3'd1;
      enc_o.bytes[0] = {1'b0, value_i[6:0]};
    end else if (value_i[30:11] == '0) begin
      enc_o.count    = 3'd2;
      enc_o.bytes[0] = LEAD_2 | {3'b000, value_i[10:6]};
      enc_o.bytes[1] = cont_byte(value_i[5:0]);
    end else if (value_i[30:16] == '0) begin
      enc_o.count    = 3'd3;
      enc_o.bytes[0] = LEAD_3 | {4'b0000, value_i[15:12]};
      enc_o.bytes[1] = cont_byte(value_i[11:6]);
      enc_o.bytes[2] = cont_byte(value_i[5:0]);
    end else if (value_i[30:21] == '0) begin
      enc_o.count    = 3'd4;
      enc_o.bytes[0] = LEAD_4 | {5'b00000, value_i[20:18]};
      enc_o.bytes[1] = cont_byte(value_i[17:12]);
      enc_o.bytes[2] = cont_byte(value_i[11:6]);
      enc_o.bytes[3] = cont_byte(value_i[5:0]);
    end else if (value_i[30:26] == '0) begin
      enc_o.count    = 3'd5;
      enc_o.bytes[0] = LEAD_5 | {6'b000000, value_i[25:24]};
      enc_o.bytes[1] = cont_byte(value_i[23:18]);
      enc_o.bytes[2] = cont_byte(value_i[17:12]);
      enc_o.bytes[3] = cont_byte(value_i[11:6]);
      enc_o.bytes[4] = cont_byte(value_i[5:0]);
    end else begin
      enc_o.count    = 3'd6;
      enc_o.bytes[0] = LEAD_6 | {7'b0000000, value_i[30]};
      enc_o.bytes[1] = cont_byte(value_i[29:24]);
      enc_o.bytes[2] = cont_byte(value_i[23:18]);
      enc_o.bytes[3] = cont_byte(value_i[17:12]);
      enc_o.bytes[4] = cont_byte(value_i[11:6]);
      enc_o.bytes[5] = cont_byte(value_i[5:0]);
    end
  end

endmodule

// ----- rtl/divider_set_lookup_utf8_read_unit.sv -----
// Divider-set lookup unit: sorted code-point table with binary-search query
// and UTF-8 read-out. A word is taken when start is high and busy is low; one
// result word appears on the outputs for exactly one cycle with done_o high,
// and the receiver cannot stall it. Clear, append, a query that needs no table
// access and a read of the built-in set complete in the execute state; a read
// of a table entry adds a wait state for one memory read; a table query goes
// on to a search state for the binary-search probes, at most clog2(count+1),
// i.e. up to 11 probes at 1024 entries.
// Each probe is one read of the single table RAM, and the next probe address
// is formed from the returned entry in the same cycle. One word is in flight
// at a time; busy drops in the cycle that done_o is high, so the next word can
// be taken there. Configuration writes are always ready. No clearing pass: the
// entry count alone decides which table entries are live.
module divider_set_lookup_utf8_read_unit import dslu_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_wdata_i,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation_i,
  input  logic [CP_W-1:0]     code_point_i,
  input  logic [IDX_W-1:0]    entry_index_i,
  output logic                done_o,
  output logic                is_divider_o,
  output logic [2:0]          byte_count_o,
  output logic [7:0]          enc_byte_0_o,
  output logic [7:0]          enc_byte_1_o,
  output logic [7:0]          enc_byte_2_o,
  output logic [7:0]          enc_byte_3_o,
  output logic [7:0]          enc_byte_4_o,
  output logic [7:0]          enc_byte_5_o,
  output logic [TOTAL_W-1:0]  entry_total_o,
  output logic [1:0]          status_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_RDWAIT = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [1:0]        op_q;
  logic [CP_W-1:0]   code_q;
  logic [IDX_W-1:0]  idx_q;
  logic [1:0]        src_q;
  logic [CW-1:0]     count_q, count_d;
  logic [CP_W-1:0]   last_q, last_d;
  logic [CW-1:0]     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic              done_q, done_d;

  logic              div_q, div_d;
  logic              use_enc;
  logic [1:0]        status_q, status_d;
  logic [2:0]        bcnt_q;
  logic [5:0][7:0]   bytes_q;
  logic [TOTAL_W-1:0] total_q, total_d;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CP_W-1:0]   mem_rdata;

  logic [CP_W-1:0]   enc_val;
  utf8_t             enc;

  logic              lt;
  logic [CW-1:0]     lo_n, hi_n;
  logic [CW:0]       mid_sum;
  logic [TOTAL_W+CW-1:0] cnt_ext;

  dslu_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (CP_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (code_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign enc_val = (state_q == S_RDWAIT) ? mem_rdata
                 : {{(CP_W-7){1'b0}}, BUILTIN_LUT[idx_q[BUILTIN_IW-1:0]]};

  dslu_utf8_enc u_enc (
    .value_i (enc_val),
    .enc_o   (enc)
  );

  // Next probe bounds from the entry that just came back.
  assign lt      = mem_rdata < code_q;
  assign lo_n    = lt ? mid_q + CW'(1) : lo_q;
  assign hi_n    = lt ? hi_q : mid_q;
  assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    last_d    = last_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    done_d    = 1'b0;
    div_d     = 1'b0;
    use_enc   = 1'b0;
    status_d  = STATUS_OK;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = mid_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        case (op_q)
          OP_CLEAR: begin
            count_d = '0;
            last_d  = '0;
          end
          OP_APPEND: begin
            if (count_q == CW'(TABLE_DEPTH)) begin
              status_d = STATUS_FULL;
            end else if (count_q != '0 && code_q < last_q) begin
              status_d = STATUS_ORDER;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + CW'(1);
              last_d  = code_q;
            end
          end
          OP_QUERY: begin
            if (code_q == '0) begin
              div_d = 1'b1;
            end else if (src_q == SRC_BUILTIN) begin
              div_d = (code_q[CP_W-1:7] == '0) && !is_alnum_ascii(code_q[6:0]);
            end else if (src_q == SRC_TABLE && count_q != '0) begin
              lo_d      = '0;
              hi_d      = count_q;
              mid_d     = count_q >> 1;
              mem_re    = 1'b1;
              mem_raddr = mid_d[AW-1:0];
              done_d    = 1'b0;
              state_d   = S_SEARCH;
            end
          end
          default: begin
            if (src_q == SRC_TABLE && 32'(idx_q) < 32'(count_q)) begin
              mem_re    = 1'b1;
              mem_raddr = idx_q[AW-1:0];
              done_d    = 1'b0;
              state_d   = S_RDWAIT;
            end else if (src_q == SRC_BUILTIN && 32'(idx_q) < BUILTIN_TOTAL) begin
              use_enc = 1'b1;
            end else begin
              status_d = STATUS_RANGE;
            end
          end
        endcase
      end
      S_SEARCH: begin
        if (mem_rdata == code_q) begin
          div_d   = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (lo_n < hi_n) begin
          lo_d      = lo_n;
          hi_d      = hi_n;
          mid_d     = mid_sum[CW:1];
          mem_re    = 1'b1;
          mem_raddr = mid_d[AW-1:0];
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RDWAIT: begin
        use_enc = 1'b1;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Active set size after the word's effect on the table.
  assign cnt_ext = {{TOTAL_W{1'b0}}, count_d};

  always_comb begin
    case (src_q)
      SRC_TABLE:   total_d = cnt_ext[TOTAL_W-1:0];
      SRC_BUILTIN: total_d = TOTAL_W'(BUILTIN_TOTAL);
      default:     total_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      src_q   <= SRC_TABLE;
      count_q <= '0;
      last_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      last_q  <= last_d;
      done_q  <= done_d;
      if (cfg_valid_i) begin
        src_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      op_q   <= operation_i;
      code_q <= code_point_i;
      idx_q  <= entry_index_i;
    end
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    if (done_d) begin
      div_q    <= div_d;
      status_q <= status_d;
      total_q  <= total_d;
      bcnt_q   <= use_enc ? enc.count : 3'd0;
      bytes_q  <= use_enc ? enc.bytes : '0;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign is_divider_o  = div_q;
  assign byte_count_o  = bcnt_q;
  assign enc_byte_0_o  = bytes_q[0];
  assign enc_byte_1_o  = bytes_q[1];
  assign enc_byte_2_o  = bytes_q[2];
  assign enc_byte_3_o  = bytes_q[3];
  assign enc_byte_4_o  = bytes_q[4];
  assign enc_byte_5_o  = bytes_q[5];
  assign entry_total_o = total_q;
  assign status_o      = status_q;

endmodule

// ----- rtl/dslu_checker.sv -----
// Port-level checks of the divider-set lookup unit, bound to the top level.
`include "divider_set_lookup_utf8_read_unit_assert.svh"

module dslu_checker import dslu_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic       is_divider_o,
  input logic [2:0] byte_count_o,
  input logic [7:0] enc_byte_0_o,
  input logic [7:0] enc_byte_1_o,
  input logic [7:0] enc_byte_2_o,
  input logic [7:0] enc_byte_3_o,
  input logic [7:0] enc_byte_4_o,
  input logic [7:0] enc_byte_5_o,
  input logic [1:0] status_o
);

  // A taken word keeps the unit busy for at least the next cycle.
  `DSLU_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // One word in flight: results never come back to back.
  `DSLU_ASSERT_NXT(a_done_single, done_o, !done_o)
  // The result cycle frees the unit.
  `DSLU_ASSERT_NOW(a_done_idle, done_o, !busy)
  // No encoded bytes without a byte count.
  `DSLU_ASSERT_NOW(a_no_stray_bytes, done_o && byte_count_o == 3'd0,
    enc_byte_0_o == 8'd0 && enc_byte_1_o == 8'd0 && enc_byte_2_o == 8'd0 &&
    enc_byte_3_o == 8'd0 && enc_byte_4_o == 8'd0 && enc_byte_5_o == 8'd0)
  // A hit is a plain query: clean status, nothing encoded.
  `DSLU_ASSERT_NOW(a_hit_clean, done_o && is_divider_o,
    status_o == STATUS_OK && byte_count_o == 3'd0)

endmodule

bind divider_set_lookup_utf8_read_unit dslu_checker u_dslu_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the divider-set lookup unit: random and directed words.
module testbench import dslu_pkg::*;;

  localparam int TBL_DEPTH     = 1024;
  localparam int SETTLE_CYCLES = 16;

  typedef enum logic [1:0] {
    W_ITEM  = 2'd0,
    W_CFG   = 2'd1,
    W_DRAIN = 2'd2
  } word_kind_e;

  typedef struct packed {
    word_kind_e       kind;
    op_e              op;
    logic [CP_W-1:0]  cp;
    logic [IDX_W-1:0] idx;
    src_e             src;
  } stim_word_t;

  typedef struct packed {
    logic               is_div;
    utf8_t              enc;
    logic [TOTAL_W-1:0] total;
    status_e            status;
  } lookup_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_wdata_i   = '0;
  logic               start         = 1'b0;
  logic               busy;
  logic [1:0]         operation_i   = '0;
  logic [CP_W-1:0]    code_point_i  = '0;
  logic [IDX_W-1:0]   entry_index_i = '0;
  logic               done_o;
  logic               is_divider_o;
  logic [2:0]         byte_count_o;
  logic [7:0]         enc_byte_0_o;
  logic [7:0]         enc_byte_1_o;
  logic [7:0]         enc_byte_2_o;
  logic [7:0]         enc_byte_3_o;
  logic [7:0]         enc_byte_4_o;
  logic [7:0]         enc_byte_5_o;
  logic [TOTAL_W-1:0] entry_total_o;
  logic [1:0]         status_o;

  divider_set_lookup_utf8_read_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .code_point_i  (code_point_i),
    .entry_index_i (entry_index_i),
    .done_o        (done_o),
    .is_divider_o  (is_divider_o),
    .byte_count_o  (byte_count_o),
    .enc_byte_0_o  (enc_byte_0_o),
    .enc_byte_1_o  (enc_byte_1_o),
    .enc_byte_2_o  (enc_byte_2_o),
    .enc_byte_3_o  (enc_byte_3_o),
    .enc_byte_4_o  (enc_byte_4_o),
    .enc_byte_5_o  (enc_byte_5_o),
    .entry_total_o (entry_total_o),
    .status_o      (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Divider-set predictor: own copy of table, count, last append and source
  // ---------------------------------------------------------------------------
  logic [CP_W-1:0] tbl_mem [TBL_DEPTH];
  int              tbl_count = 0;
  logic [CP_W-1:0] tbl_last  = '0;
  src_e            cur_src   = SRC_TABLE;

  function automatic logic ascii_alnum(logic [6:0] c);
    return (c >= 7'h30 && c <= 7'h39) || (c >= 7'h41 && c <= 7'h5A) ||
           (c >= 7'h61 && c <= 7'h7A);
  endfunction

  function automatic logic [CP_W-1:0] builtin_nth(int k);
    int n;
    n = 0;
    for (int c = 1; c < 128; c++) begin
      if (!ascii_alnum(7'(c))) begin
        if (n == k) return CP_W'(c);
        n++;
      end
    end
    return '0;
  endfunction

  function automatic logic table_holds(logic [CP_W-1:0] cp);
    int lo, hi, mid;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_mem[mid] == cp) return 1'b1;
      if (tbl_mem[mid] < cp) lo = mid + 1;
      else hi = mid;
    end
    return 1'b0;
  endfunction

  function automatic int set_total();
    case (cur_src)
      SRC_TABLE:   return tbl_count;
      SRC_BUILTIN: return BUILTIN_TOTAL;
      default:     return 0;
    endcase
  endfunction

  function automatic utf8_t utf8_encode(logic [CP_W-1:0] cp);
    utf8_t           u;
    logic [CP_W-1:0] v;
    int              n;
    logic [7:0]      lead;
    u = '0;
    v = cp;
    if (cp < 31'h80) begin
      u.count    = 3'd1;
      u.bytes[0] = cp[7:0];
      return u;
    end
    if (cp < 31'h800) begin n = 2; lead = LEAD_2; end
    else if (cp < 31'h10000) begin n = 3; lead = LEAD_3; end
    else if (cp < 31'h200000) begin n = 4; lead = LEAD_4; end
    else if (cp < 31'h4000000) begin n = 5; lead = LEAD_5; end
    else begin n = 6; lead = LEAD_6; end
    for (int i = n - 1; i > 0; i--) begin
      u.bytes[i] = CONT_MARK | (v[7:0] & CONT_MASK);
      v = v >> 6;
    end
    u.bytes[0] = lead | v[7:0];
    u.count    = 3'(n);
    return u;
  endfunction

  function automatic lookup_result_t lookup_predict(op_e op, logic [CP_W-1:0] cp,
                                                    logic [IDX_W-1:0] idx);
    lookup_result_t r;
    r = '0;
    case (op)
      OP_CLEAR: begin
        tbl_count = 0;
        tbl_last  = '0;
      end
      OP_APPEND: begin
        if (tbl_count >= TBL_DEPTH) r.status = STATUS_FULL;
        else if (tbl_count > 0 && cp < tbl_last) r.status = STATUS_ORDER;
        else begin
          tbl_mem[tbl_count] = cp;
          tbl_count++;
          tbl_last = cp;
        end
      end
      OP_QUERY: begin
        if (cp == '0) r.is_div = 1'b1;
        else if (cur_src == SRC_TABLE) r.is_div = table_holds(cp);
        else if (cur_src == SRC_BUILTIN) r.is_div = (cp <= 31'd127) && !ascii_alnum(cp[6:0]);
      end
      OP_READ: begin
        if (int'(idx) >= set_total()) r.status = STATUS_RANGE;
        else if (cur_src == SRC_TABLE) r.enc = utf8_encode(tbl_mem[idx]);
        else r.enc = utf8_encode(builtin_nth(int'(idx)));
      end
      default: ;
    endcase
    r.total = TOTAL_W'(set_total());
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops pending words, keeps start and cfg_valid_i, predicts on accept
  // ---------------------------------------------------------------------------
  stim_word_t     pending [$];
  lookup_result_t expected_results [$];
  int             fail_n    = 0;
  int             sent_n    = 0;
  int             hold_n    = 0;
  logic           in_flight = 1'b0;
  logic           start_nxt, cfgv_nxt;
  stim_word_t     w;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start         <= 1'b0;
      cfg_valid_i   <= 1'b0;
      cfg_wdata_i   <= '0;
      operation_i   <= '0;
      code_point_i  <= '0;
      entry_index_i <= '0;
      hold_n        = 0;
      in_flight     = 1'b0;
    end else begin
      start_nxt = start;
      cfgv_nxt  = cfg_valid_i;
      if (done_o) in_flight = 1'b0;
      if (start && !busy) begin
        expected_results.push_back(lookup_predict(op_e'(operation_i), code_point_i,
                                                  entry_index_i));
        in_flight = 1'b1;
        start_nxt = 1'b0;
        sent_n++;
        // every fourth stretch of 50 words runs back to back
        hold_n = (((sent_n / 50) % 4) == 3) ? 0 : $urandom_range(0, 17);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cur_src  = src_e'(cfg_wdata_i);
        cfgv_nxt = 1'b0;
      end
      if (!start_nxt && !cfgv_nxt) begin
        if (hold_n > 0) hold_n--;
        else if (pending.size() > 0) begin
          w = pending[0];
          case (w.kind)
            W_ITEM: begin
              void'(pending.pop_front());
              operation_i   <= w.op;
              code_point_i  <= w.cp;
              entry_index_i <= w.idx;
              start_nxt     = 1'b1;
            end
            W_CFG: begin
              void'(pending.pop_front());
              cfg_wdata_i <= w.src;
              cfgv_nxt    = 1'b1;
            end
            default: begin
              if (!in_flight) begin
                void'(pending.pop_front());
                hold_n = SETTLE_CYCLES;
              end
            end
          endcase
        end
      end
      start       <= start_nxt;
      cfg_valid_i <= cfgv_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each done_o word against the oldest expectation
  // ---------------------------------------------------------------------------
  lookup_result_t got_exp;

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_n++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result word with no expectation waiting");
        fail_n++;
      end else begin
        got_exp = expected_results.pop_front();
        check_field("is_divider", got_exp.is_div, is_divider_o);
        check_field("byte_count", got_exp.enc.count, byte_count_o);
        check_field("enc_byte_0", got_exp.enc.bytes[0], enc_byte_0_o);
        check_field("enc_byte_1", got_exp.enc.bytes[1], enc_byte_1_o);
        check_field("enc_byte_2", got_exp.enc.bytes[2], enc_byte_2_o);
        check_field("enc_byte_3", got_exp.enc.bytes[3], enc_byte_3_o);
        check_field("enc_byte_4", got_exp.enc.bytes[4], enc_byte_4_o);
        check_field("enc_byte_5", got_exp.enc.bytes[5], enc_byte_5_o);
        check_field("entry_total", got_exp.total, entry_total_o);
        check_field("status", got_exp.status, status_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus; the generator keeps its own view of the table to aim queries
  // ---------------------------------------------------------------------------
  logic [CP_W-1:0] gen_vals [$];
  logic [CP_W-1:0] gen_last = '0;
  src_e            gen_src  = SRC_TABLE;

  task automatic push_item(op_e op, logic [CP_W-1:0] cp, logic [IDX_W-1:0] idx);
    stim_word_t s;
    s      = '0;
    s.kind = W_ITEM;
    s.op   = op;
    s.cp   = cp;
    s.idx  = idx;
    pending.push_back(s);
  endtask

  task automatic push_drain();
    stim_word_t s;
    s      = '0;
    s.kind = W_DRAIN;
    pending.push_back(s);
  endtask

  // register writes only once the block has gone idle
  task automatic push_cfg(src_e src);
    stim_word_t s;
    s      = '0;
    s.kind = W_CFG;
    s.src  = src;
    push_drain();
    pending.push_back(s);
    gen_src = src;
  endtask

  task automatic gen_append(logic [CP_W-1:0] v);
    push_item(OP_APPEND, v, IDX_W'($urandom()));
    if (gen_vals.size() < TBL_DEPTH && (gen_vals.size() == 0 || v >= gen_last)) begin
      gen_vals.push_back(v);
      gen_last = v;
    end
  endtask

  task automatic gen_clear();
    push_item(OP_CLEAR, CP_W'($urandom()), IDX_W'($urandom()));
    gen_vals.delete();
    gen_last = '0;
  endtask

  function automatic logic [CP_W-1:0] gen_value();
    logic [31:0] step;
    logic [32:0] sum;
    if (gen_vals.size() == 0) begin
      case ($urandom_range(0, 2))
        0:       return CP_W'($urandom_range(0, 127));
        1:       return CP_W'($urandom_range(0, 32'hFFFF));
        default: return CP_W'($urandom());
      endcase
    end
    case ($urandom_range(0, 4))
      0:       step = 0;
      1:       step = $urandom_range(1, 4);
      2:       step = $urandom_range(1, 255);
      3:       step = $urandom() & 32'hFFFF;
      default: step = $urandom() & 32'hFF_FFFF;
    endcase
    sum = {2'b00, gen_last} + {1'b0, step};
    if (sum > 33'h7FFF_FFFF) return '1;
    return sum[CP_W-1:0];
  endfunction

  function automatic logic [CP_W-1:0] gen_query_cp();
    int r;
    r = $urandom_range(0, 99);
    if (gen_vals.size() > 0 && r < 45) return gen_vals[$urandom_range(0, gen_vals.size() - 1)];
    if (gen_vals.size() > 0 && r < 55)
      return CP_W'(gen_vals[$urandom_range(0, gen_vals.size() - 1)] +
                   ($urandom_range(0, 1) ? 1 : -1));
    if (r < 70) return CP_W'($urandom_range(0, 127));
    if (r < 75) return '0;
    return CP_W'($urandom());
  endfunction

  function automatic int gen_total();
    case (gen_src)
      SRC_TABLE:   return gen_vals.size();
      SRC_BUILTIN: return BUILTIN_TOTAL;
      default:     return 0;
    endcase
  endfunction

  initial begin
    int   random_n;
    int   n_app, n_ops, r;
    src_e src;
    logic [CP_W-1:0] v;

    // directed: empty table, UTF-8 length boundaries, order check, extremes
    push_item(OP_QUERY, '0, '0);
    push_item(OP_READ, '0, '0);
    gen_append(31'h0);
    gen_append(31'h7F);
    gen_append(31'h80);
    gen_append(31'h7FF);
    gen_append(31'h800);
    gen_append(31'hFFFF);
    gen_append(31'h10000);
    gen_append(31'h1F_FFFF);
    gen_append(31'h20_0000);
    gen_append(31'h3FF_FFFF);
    gen_append(31'h400_0000);
    gen_append(31'h7FFF_FFFF);
    gen_append(31'h5);
    gen_append(31'h7FFF_FFFF);
    push_item(OP_QUERY, 31'h7FFF_FFFF, '0);
    push_item(OP_QUERY, 31'h7FFF_FFFE, '0);
    push_item(OP_READ, '0, 10'd11);
    push_item(OP_READ, '0, 10'd8);
    push_item(OP_READ, '0, 10'd1023);
    push_cfg(SRC_BUILTIN);
    push_item(OP_QUERY, 31'h7F, '0);
    push_item(OP_READ, '0, 10'd64);
    push_item(OP_READ, '0, 10'd65);
    push_cfg(SRC_UNUSED);
    push_item(OP_QUERY, 31'h20, '0);

    // random phases: a source setting, often a fresh sorted table, mixed traffic;
    // sized so the full-table phase below brings the total near 1300 words
    random_n = 0;
    while (random_n < 185) begin
      r = $urandom_range(0, 9);
      if (r < 5) src = SRC_TABLE;
      else if (r < 7) src = SRC_BUILTIN;
      else if (r == 7) src = SRC_EMPTY;
      else if (r == 8) src = SRC_UNUSED;
      else src = src_e'($urandom_range(0, 3));
      push_cfg(src);
      if ($urandom_range(0, 4) != 0 || gen_vals.size() > 150) begin
        gen_clear();
        random_n++;
      end
      n_app = $urandom_range(0, 40);
      for (int i = 0; i < n_app; i++) begin
        if (gen_vals.size() > 0 && gen_last > 0 && $urandom_range(0, 11) == 0)
          gen_append(CP_W'(gen_last - 1 - CP_W'($urandom_range(0, 3))));  // out of order
        else
          gen_append(gen_value());
      end
      random_n += n_app;
      n_ops = $urandom_range(10, 50);
      for (int i = 0; i < n_ops; i++) begin
        r = $urandom_range(0, 99);
        if (r < 40) push_item(OP_QUERY, gen_query_cp(), IDX_W'($urandom()));
        else if (r < 80) begin
          if ($urandom_range(0, 9) < 7)
            push_item(OP_READ, CP_W'($urandom()), IDX_W'($urandom_range(0, gen_total() + 3)));
          else
            push_item(OP_READ, CP_W'($urandom()), IDX_W'($urandom_range(0, 1023)));
        end
        else if (r < 90) gen_append(gen_value());
        else if (r < 93) gen_clear();
        else begin
          // noise word, all fields random
          v = CP_W'($urandom());
          case (op_e'($urandom_range(0, 3)))
            OP_CLEAR:  gen_clear();
            OP_APPEND: gen_append(v);
            OP_QUERY:  push_item(OP_QUERY, v, IDX_W'($urandom()));
            default:   push_item(OP_READ, v, IDX_W'($urandom()));
          endcase
        end
        if ($urandom_range(0, 60) == 0) push_drain();
      end
      random_n += n_ops;
    end

    // full table: deepest search, full status, top index
    push_cfg(SRC_TABLE);
    gen_clear();
    v = CP_W'($urandom_range(0, 1000));
    for (int i = 0; i < TBL_DEPTH; i++) begin
      gen_append(v);
      v = v + CP_W'($urandom_range(0, 32'h1F_FFFF));
    end
    for (int i = 0; i < 4; i++) gen_append(v);
    for (int i = 0; i < 60; i++) begin
      if ($urandom_range(0, 1)) push_item(OP_QUERY, gen_query_cp(), '0);
      else push_item(OP_READ, '0, IDX_W'($urandom_range(0, 1023)));
    end
    push_item(OP_READ, '0, 10'd1023);
    push_cfg(SRC_EMPTY);
    push_item(OP_READ, '0, '0);

    while (pending.size() != 0 || in_flight || start || cfg_valid_i) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_n++;
    end
    if (fail_n == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/dslu_pkg.sv
rtl/dslu_table_mem.sv
rtl/dslu_utf8_enc.sv
rtl/divider_set_lookup_utf8_read_unit.sv
rtl/dslu_checker.sv
verif/testbench.sv
